// ===== rtl/modular_exponentiation_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication
`define MEXP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MEXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register indexes, status struct and modular add helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int DATA_W    = 64;                    // port field width
  localparam int WORD_BITS = 64;                    // datapath width, 8..64
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int CFG_IDX_W = 8;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = CFG_IDX_W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // (a + b) mod m for a < m and b < m, without growing past the word
  function automatic word_t add_mod(word_t a, word_t b, word_t m);
    word_t room;
    room = m - b;
    if (a >= room) begin
      return a - room;
    end else begin
      return a + b;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial shift-add modular multiplier, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire mexp_pkg::word_t   op_a,   // must be below modulus
  input  wire mexp_pkg::word_t   op_b,
  input  wire mexp_pkg::word_t   modulus, // held steady while busy
  output mexp_pkg::mul_stat_t    stat,
  output mexp_pkg::word_t        result
);

  mexp_pkg::word_t acc_r, acc_nxt;
  mexp_pkg::word_t a_r;
  mexp_pkg::word_t b_r;
  mexp_pkg::cnt_t  cnt_r;
  logic            busy_r;
  logic            done_r;
  mexp_pkg::word_t dbl;

  // double, then add a when the current bit of b is set
  always_comb begin
    dbl     = mexp_pkg::add_mod(acc_r, acc_r, modulus);
    acc_nxt = b_r[mexp_pkg::WORD_BITS-1] ? mexp_pkg::add_mod(dbl, a_r, modulus) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mexp_pkg::cnt_t'(mexp_pkg::WORD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= op_a;
      b_r   <= op_b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = acc_r;

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation: base ** exponent mod modulus, one result per item
// Each modular product runs on the bit-serial multiplier; an item
// needs one reduction, one multiply per set exponent bit and one square per
// exponent bit below the top set one.
// One item at a time. Synchronous active-low reset; exponent and modulus reset to 1.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mexp_pkg::DATA_W-1:0]   in_tdata,   // [63:0] base_value
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [mexp_pkg::DATA_W-1:0]        out_tdata,  // [63:0] power_result
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mexp_pkg::DATA_W-1:0]   cfg_data
);

  // Sequencer: LOAD starts the base reduction, CHECK picks the next product
  // from the low exponent bit, MUL/SQR wait on the shared multiplier.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_RED   = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SQR   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  mexp_pkg::word_t     exp_r;
  mexp_pkg::word_t     mod_r;
  mexp_pkg::word_t     e_r;       // remaining exponent bits
  mexp_pkg::word_t     acc_r;     // running product
  mexp_pkg::word_t     sq_r;      // running square of the base
  mexp_pkg::word_t     out_data_r;
  logic                out_valid_r;
  mexp_pkg::word_t     one_mod;
  logic                in_acc;
  logic                out_load;
  logic                mul_start;
  mexp_pkg::word_t     mul_a;
  mexp_pkg::mul_stat_t mul_stat;
  mexp_pkg::word_t     mul_res;

  // Configuration: always ready, writes beyond the list drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= mexp_pkg::word_t'(1);
      mod_r <= mexp_pkg::word_t'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mexp_pkg::CFG_EXPONENT: exp_r <= mexp_pkg::word_t'(cfg_data);
        mexp_pkg::CFG_MODULUS:  mod_r <= mexp_pkg::word_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // 1 mod m: zero when the modulus is one
  assign one_mod = (mod_r == mexp_pkg::word_t'(1)) ? '0 : mexp_pkg::word_t'(1);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // Hand the finished result to the output register once it is free.
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Reduction runs as one_mod * base; products in CHECK use acc or sq as a.
  assign mul_start = (state_r == S_LOAD) || ((state_r == S_CHECK) && (e_r != '0));
  assign mul_a     = ((state_r == S_CHECK) && !e_r[0]) ? sq_r : acc_r;

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (sq_r),
    .modulus (mod_r),
    .stat    (mul_stat),
    .result  (mul_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (mod_r == '0) ? S_DONE : S_LOAD;
      S_LOAD:  state_nxt = S_RED;
      S_RED:   if (mul_stat.done) state_nxt = S_CHECK;
      S_CHECK: begin
        if (e_r == '0) begin
          state_nxt = S_DONE;
        end else if (e_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL:   if (mul_stat.done) state_nxt = S_CHECK;
      S_SQR:   if (mul_stat.done) state_nxt = S_CHECK;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      // zero modulus gives zero; otherwise start from acc = 1 mod m
      acc_r <= (mod_r == '0) ? '0 : one_mod;
      sq_r  <= mexp_pkg::word_t'(in_tdata);
      e_r   <= exp_r;
    end else if (mul_stat.done) begin
      unique case (state_r)
        S_RED: sq_r <= mul_res;
        S_MUL: begin
          acc_r <= mul_res;
          e_r   <= {e_r[mexp_pkg::WORD_BITS-1:1], 1'b0};
        end
        S_SQR: begin
          sq_r <= mul_res;
          e_r  <= e_r >> 1;
        end
        default: ;
      endcase
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mexp_pkg::DATA_W'(out_data_r);

  `MEXP_ASSERT_IMP(a_start_free, mul_start, !mul_stat.busy, "multiplier restarted while busy")
  `MEXP_ASSERT_IMP(a_prod_range, mul_stat.done && (mod_r != '0), mul_res < mod_r, "product not reduced")
  `MEXP_ASSERT_NXT(a_out_range, out_load, (mod_r == '0) || (out_data_r < mod_r), "result not below modulus")

endmodule

`default_nettype wire

// ===== dv/modular_exponentiation_tb.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation core. An initial block
// sets exponent and modulus, queues base values and waits for the core to
// drain before it changes the setting again. A clocked driver and a clocked
// monitor move items on both streams with random idle bursts. A predictor
// built on full-width products checks every result against the expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = mexp_pkg::DATA_W;
  localparam int WB = mexp_pkg::WORD_BITS;
  localparam int IW = mexp_pkg::CFG_IDX_W;

  // indexes past the register list; the core must ignore writes to them
  localparam logic [IW-1:0] CFG_IDX_SPARE_LOW  = mexp_pkg::CFG_MODULUS + IW'(1);
  localparam logic [IW-1:0] CFG_IDX_SPARE_HIGH = '1;

  localparam logic [DW-1:0] ALL_ONES    = '1;
  localparam logic [DW-1:0] PRIME_TOP   = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64 - 59
  localparam logic [DW-1:0] EXP_F4      = 64'd65537;

  typedef mexp_pkg::word_t word_t;

  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           in_tvalid  = 1'b0;
  logic           in_tready;
  logic [DW-1:0]  in_tdata   = '0;     // [63:0] base_value
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [DW-1:0]  out_tdata;           // [63:0] power_result
  logic           cfg_valid  = 1'b0;
  logic           cfg_ready;
  logic [IW-1:0]  cfg_index  = '0;
  logic [DW-1:0]  cfg_data   = '0;

  // shadow of the core's registers, as seen after the last accepted write
  word_t          cur_exponent = word_t'(1);
  word_t          cur_modulus  = word_t'(1);

  logic [DW-1:0]  pending_bases[$];
  word_t          expected_powers[$];
  int             err_count    = 0;

  // idle controls; the initial block toggles them per phase
  bit             src_idle_en  = 1'b0;
  bit             snk_idle_en  = 1'b0;
  int             src_gap      = 0;
  int             snk_gap      = 0;

  always #5 clk = ~clk;

  modular_exponentiation u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Right-to-left square-and-multiply. Each product is formed at double width
  // and reduced at once, so no modular adder is needed here.
  function automatic word_t predict_power(word_t base, word_t e, word_t m);
    logic [2*WB-1:0] prod;
    word_t           acc;
    word_t           sq;
    if (m == '0) begin
      return '0;
    end
    acc = word_t'(1) % m;
    sq  = base % m;
    for (int i = 0; i < WB; i++) begin
      if (e[i]) begin
        prod = acc * sq;
        acc  = word_t'(prod % m);
      end
      prod = sq * sq;
      sq   = word_t'(prod % m);
    end
    return acc;
  endfunction

  function automatic logic [DW-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: pull base values from the pending queue; predict on acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_powers.push_back(predict_power(word_t'(in_tdata), cur_exponent,
                                                cur_modulus));
      end
      // advance only when the slot is free; never drop an offered item
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          in_tvalid <= 1'b0;
          src_gap   <= src_gap - 1;
        end else if (src_idle_en && pending_bases.size() > 0 &&
                     $urandom_range(0, 3) == 0) begin
          // start an idle burst, its length drawn at random
          in_tvalid <= 1'b0;
          src_gap   <= $urandom_range(0, 3);
        end else if (pending_bases.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_bases.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result stream in bursts; check each accepted item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      snk_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected power_result", word_t'(out_tdata), '0);
        end else begin
          word_t want;
          want = expected_powers.pop_front();
          if (word_t'(out_tdata) !== want) begin
            report_mismatch("power_result", word_t'(out_tdata), want);
          end
        end
      end
      if (snk_gap > 0) begin
        out_tready <= 1'b0;
        snk_gap    <= snk_gap - 1;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        snk_gap    <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Write one register; update the shadow copy once the write is taken.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mexp_pkg::CFG_EXPONENT) begin
      cur_exponent = word_t'(data);
    end else if (idx == mexp_pkg::CFG_MODULUS) begin
      cur_modulus = word_t'(data);
    end
  endtask

  // Hold until every queued base is taken and every result has come back.
  task automatic drain();
    while (pending_bases.size() > 0 || in_tvalid || expected_powers.size() > 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Exponent of random length: mostly short, sometimes full width.
  function automatic logic [DW-1:0] rand_exponent(bit full);
    int w;
    w = full ? DW : $urandom_range(1, 20);
    return rand_word() & (ALL_ONES >> (DW - w));
  endfunction

  function automatic logic [DW-1:0] rand_modulus();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        return ALL_ONES;
      end
      1: begin
        return logic'(1);
      end
      2: begin
        return '0;
      end
      3, 4: begin
        return (rand_word() >> $urandom_range(8, 60)) | 64'd2;
      end
      default: begin
        return rand_word() | (64'd1 << (DW - 1));
      end
    endcase
  endfunction

  // Base: full random, or already reduced below the modulus.
  function automatic logic [DW-1:0] rand_base(logic [DW-1:0] m);
    if ($urandom_range(0, 1) == 0 || m == '0) begin
      return rand_word();
    end
    return rand_word() % m;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int               n_phases;
    int               n_items;
    logic [DW-1:0]    e_val;
    logic [DW-1:0]    m_val;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    // reset setting: exponent 1, modulus 1, so every result is zero
    pending_bases.push_back('0);
    pending_bases.push_back(ALL_ONES);
    drain();

    // exponent zero gives one under any modulus above one
    write_reg(mexp_pkg::CFG_EXPONENT, '0);
    write_reg(mexp_pkg::CFG_MODULUS, ALL_ONES);
    pending_bases.push_back('0);
    pending_bases.push_back(64'd5);
    drain();

    // widest exponent and modulus; all-ones base equals the modulus
    write_reg(mexp_pkg::CFG_EXPONENT, ALL_ONES);
    pending_bases.push_back('0);
    pending_bases.push_back(64'd1);
    pending_bases.push_back(64'd2);
    pending_bases.push_back(ALL_ONES);
    pending_bases.push_back(ALL_ONES - 64'd1);
    drain();

    // public exponent against a large prime; bases above the modulus too
    write_reg(mexp_pkg::CFG_EXPONENT, EXP_F4);
    write_reg(mexp_pkg::CFG_MODULUS, PRIME_TOP);
    pending_bases.push_back(ALL_ONES);
    pending_bases.push_back(PRIME_TOP);
    pending_bases.push_back(rand_word());
    drain();

    // writes past the register list must leave the setting untouched
    write_reg(CFG_IDX_SPARE_LOW, 64'd3);
    write_reg(CFG_IDX_SPARE_HIGH, ALL_ONES);
    pending_bases.push_back(64'd12345);
    pending_bases.push_back(rand_word());
    drain();

    // zero modulus yields zero
    write_reg(mexp_pkg::CFG_MODULUS, '0);
    pending_bases.push_back(rand_word());
    pending_bases.push_back(ALL_ONES);
    drain();

    // modulus one yields zero for any exponent
    write_reg(mexp_pkg::CFG_MODULUS, 64'd1);
    write_reg(mexp_pkg::CFG_EXPONENT, rand_word());
    pending_bases.push_back(rand_word());
    pending_bases.push_back(64'd7);
    drain();

    // random phases; the last one runs with no idling on either side
    n_phases = 8;
    for (int p = 0; p < n_phases; p++) begin
      src_idle_en = (p == n_phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      snk_idle_en = (p == n_phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      e_val = rand_exponent(p == 2 || p == 5 || $urandom_range(0, 3) == 0);
      m_val = rand_modulus();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(mexp_pkg::CFG_EXPONENT, e_val);
        write_reg(mexp_pkg::CFG_MODULUS, m_val);
      end else begin
        write_reg(mexp_pkg::CFG_MODULUS, m_val);
        write_reg(mexp_pkg::CFG_EXPONENT, e_val);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(IW'($urandom_range(int'(CFG_IDX_SPARE_LOW), int'(CFG_IDX_SPARE_HIGH))),
                  rand_word());
      end
      n_items = (p < 4) ? 11 : 10;
      for (int k = 0; k < n_items; k++) begin
        pending_bases.push_back(rand_base(m_val));
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #(64'd50_000_000);
    $display("[%0t] timeout, results still outstanding: %0d", $realtime,
             expected_powers.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
dv/modular_exponentiation_tb.sv
